>>> hw/rtl/sst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Source tokenizer package
// Shared types, token kind codes and character classification helpers.
// ----------------------------------------------------------------------------
package sst_pkg;

  localparam int POS_BITS_DEF  = 16;
  localparam int LINE_BITS_DEF = 16;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_SLASH   = 4'd1,
    PH_COMMENT = 4'd2,
    PH_IDENT   = 4'd3,
    PH_INT     = 4'd4,
    PH_DOT     = 4'd5,
    PH_FRAC    = 4'd6,
    PH_OP      = 4'd7,
    PH_STRING  = 4'd8
  } phase_t;

  localparam logic [5:0] K_DOT      = 6'd8;
  localparam logic [5:0] K_SLASH    = 6'd13;
  localparam logic [5:0] K_BANG     = 6'd14;
  localparam logic [5:0] K_ASSIGN   = 6'd16;
  localparam logic [5:0] K_LESS     = 6'd18;
  localparam logic [5:0] K_GREATER  = 6'd20;
  localparam logic [5:0] K_IDENT    = 6'd22;
  localparam logic [5:0] K_NUMBER   = 6'd23;
  localparam logic [5:0] K_STRING   = 6'd24;
  localparam logic [5:0] K_EOF      = 6'd41;
  localparam logic [5:0] K_ERR_STR  = 6'd42;
  localparam logic [5:0] K_ERR_BYTE = 6'd43;

  localparam int NUM_KW = 16;

  // Keyword text is stored with the first character in the low byte.
  localparam logic [47:0] KW_TEXT [NUM_KW] = '{
    48'("cnysa"), 48'("tiawa"), 48'("ssalc"), 48'("tsnoc"),
    48'("esle"),  48'("mune"),  48'("nf"),    48'("rof"),
    48'("flteg"), 48'("fi"),    48'("tupni"), 48'("tel"),
    48'("tnirp"), 48'("nruter"), 48'("esu"),  48'("elihw")
  };
  localparam logic [2:0] KW_LEN [NUM_KW] = '{
    3'd5, 3'd5, 3'd5, 3'd5, 3'd4, 3'd4, 3'd2, 3'd3,
    3'd5, 3'd2, 3'd5, 3'd3, 3'd5, 3'd6, 3'd3, 3'd5
  };

  typedef struct packed {
    logic [5:0]  kind;
    logic [15:0] start;
    logic [15:0] length;
    logic [15:0] line;
  } token_t;

  function automatic logic [5:0] keyword_kind(input logic [47:0] prefix,
                                              input logic [2:0] len);
    logic [5:0] k;
    k = K_IDENT;
    for (int i = NUM_KW - 1; i >= 0; i--) begin
      if (len == KW_LEN[i] && prefix == KW_TEXT[i]) begin
        k = 6'(25 + i);
      end
    end
    return k;
  endfunction

  function automatic logic is_letter(input logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  function automatic logic is_op(input logic [7:0] b);
    return b == 8'h21 || b == 8'h3d || b == 8'h3c || b == 8'h3e;
  endfunction

  function automatic logic [5:0] op_kind(input logic [7:0] b);
    logic [5:0] k;
    unique case (b)
      8'h21:   k = K_BANG;
      8'h3d:   k = K_ASSIGN;
      8'h3c:   k = K_LESS;
      default: k = K_GREATER;
    endcase
    return k;
  endfunction

  // Bit 6 set means the byte is listed punctuation.
  function automatic logic [6:0] punct_kind(input logic [7:0] b);
    logic [6:0] r;
    unique case (b)
      8'h28:   r = {1'b1, 6'd0};
      8'h29:   r = {1'b1, 6'd1};
      8'h7b:   r = {1'b1, 6'd2};
      8'h7d:   r = {1'b1, 6'd3};
      8'h5b:   r = {1'b1, 6'd4};
      8'h5d:   r = {1'b1, 6'd5};
      8'h3b:   r = {1'b1, 6'd6};
      8'h2c:   r = {1'b1, 6'd7};
      8'h2e:   r = {1'b1, K_DOT};
      8'h3a:   r = {1'b1, 6'd9};
      8'h2b:   r = {1'b1, 6'd10};
      8'h2d:   r = {1'b1, 6'd11};
      8'h2a:   r = {1'b1, 6'd12};
      default: r = 7'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/sst_scan.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tokenizer scan step
// Next scanner state and up to three tokens for one source byte.
// ----------------------------------------------------------------------------
module sst_scan #(
  parameter int POS_BITS  = sst_pkg::POS_BITS_DEF,
  parameter int LINE_BITS = sst_pkg::LINE_BITS_DEF
) (
  input  wire logic [7:0]           source_byte,
  input  wire sst_pkg::phase_t      phase,
  input  wire logic [7:0]           pending,
  input  wire logic [POS_BITS-1:0]  tstart,
  input  wire logic [POS_BITS-1:0]  pos,
  input  wire logic [LINE_BITS-1:0] line,
  input  wire logic [47:0]          prefix,
  output sst_pkg::phase_t           phase_next,
  output logic [7:0]                pending_next,
  output logic [POS_BITS-1:0]       tstart_next,
  output logic [POS_BITS-1:0]       pos_next,
  output logic [LINE_BITS-1:0]      line_next,
  output logic [47:0]               prefix_next,
  output sst_pkg::token_t           toks [3],
  output logic [1:0]                count
);

  localparam int EW = (POS_BITS > 16) ? POS_BITS + 1 : 17;

  logic [7:0]           b;
  logic [POS_BITS-1:0]  span;
  logic [POS_BITS-1:0]  span_m1;
  logic [POS_BITS-1:0]  pos_adv;
  logic [LINE_BITS-1:0] line_inc;
  logic [2:0]           kw_len;
  logic [15:0]          line16;
  logic [6:0]           pk;
  logic                 go_idle;

  assign b        = source_byte;
  assign span     = (pos > tstart) ? pos - tstart : '0;
  assign span_m1  = (span != '0) ? span - 1'b1 : '0;
  assign pos_adv  = (pos == '1) ? pos : pos + 1'b1;
  assign line_inc = (line == '1) ? line : line + 1'b1;
  assign kw_len   = (span > POS_BITS'(6)) ? 3'd7 : span[2:0];
  assign line16   = 16'(line);
  assign pk       = sst_pkg::punct_kind(b);

  function automatic logic [15:0] fit16(input logic [EW-1:0] v);
    return v[15:0];
  endfunction

  always_comb begin
    phase_next   = phase;
    pending_next = pending;
    tstart_next  = tstart;
    pos_next     = pos;
    line_next    = line;
    prefix_next  = prefix;
    count        = 2'd0;
    go_idle      = 1'b0;
    for (int i = 0; i < 3; i++) begin
      toks[i] = '0;
    end

    unique case (phase)
      sst_pkg::PH_IDENT: begin
        if (sst_pkg::is_letter(b) || sst_pkg::is_digit(b) || b == 8'h5f) begin
          if (span < POS_BITS'(6)) begin
            prefix_next[8*span[2:0] +: 8] = prefix[8*span[2:0] +: 8] | b;
          end
          pos_next = pos_adv;
        end else begin
          toks[count] = '{sst_pkg::keyword_kind(prefix, kw_len), fit16(EW'(tstart)),
                          fit16(EW'(span)), line16};
          count = count + 2'd1;
          go_idle = 1'b1;
        end
      end
      sst_pkg::PH_INT, sst_pkg::PH_FRAC: begin
        if (sst_pkg::is_digit(b)) begin
          pos_next = pos_adv;
        end else if (b == 8'h2e && phase == sst_pkg::PH_INT) begin
          phase_next   = sst_pkg::PH_DOT;
          pending_next = 8'h2e;
          pos_next     = pos_adv;
        end else begin
          toks[count] = '{sst_pkg::K_NUMBER, fit16(EW'(tstart)), fit16(EW'(span)), line16};
          count = count + 2'd1;
          go_idle = 1'b1;
        end
      end
      sst_pkg::PH_DOT: begin
        if (sst_pkg::is_digit(b)) begin
          phase_next = sst_pkg::PH_FRAC;
          pos_next   = pos_adv;
        end else begin
          toks[0] = '{sst_pkg::K_NUMBER, fit16(EW'(tstart)), fit16(EW'(span_m1)), line16};
          toks[1] = '{sst_pkg::K_DOT, fit16(EW'(tstart) + EW'(span_m1)), 16'd1, line16};
          count = 2'd2;
          go_idle = 1'b1;
        end
      end
      sst_pkg::PH_OP: begin
        if (b == 8'h3d) begin
          toks[0] = '{sst_pkg::op_kind(pending) + 6'd1, fit16(EW'(tstart)), 16'd2, line16};
          count = 2'd1;
          phase_next = sst_pkg::PH_IDLE;
          pos_next   = pos_adv;
        end else begin
          toks[0] = '{sst_pkg::op_kind(pending), fit16(EW'(tstart)), 16'd1, line16};
          count = 2'd1;
          go_idle = 1'b1;
        end
      end
      sst_pkg::PH_SLASH: begin
        if (b == 8'h2f) begin
          phase_next = sst_pkg::PH_COMMENT;
          pos_next   = pos_adv;
        end else begin
          toks[0] = '{sst_pkg::K_SLASH, fit16(EW'(tstart)), 16'd1, line16};
          count = 2'd1;
          go_idle = 1'b1;
        end
      end
      sst_pkg::PH_COMMENT: begin
        if (b == 8'h00 || b == 8'h0a) begin
          go_idle = 1'b1;
        end else begin
          pos_next = pos_adv;
        end
      end
      sst_pkg::PH_STRING: begin
        if (b == 8'h00) begin
          toks[0] = '{sst_pkg::K_ERR_STR, fit16(EW'(tstart)), 16'd0, line16};
          count = 2'd1;
          go_idle = 1'b1;
        end else if (b == 8'h22) begin
          toks[0] = '{sst_pkg::K_STRING, fit16(EW'(tstart) + EW'(1)), fit16(EW'(span_m1)),
                      line16};
          count = 2'd1;
          phase_next = sst_pkg::PH_IDLE;
          pos_next   = pos_adv;
        end else begin
          if (b == 8'h0a) begin
            line_next = line_inc;
          end
          pos_next = pos_adv;
        end
      end
      default: begin
        go_idle = 1'b1;
      end
    endcase

    if (go_idle) begin
      if (b == 8'h00) begin
        toks[count] = '{sst_pkg::K_EOF, fit16(EW'(pos)), 16'd0, line16};
        count = count + 2'd1;
        pos_next   = '0;
        line_next  = LINE_BITS'(1);
        phase_next = sst_pkg::PH_IDLE;
      end else begin
        phase_next  = sst_pkg::PH_IDLE;
        tstart_next = pos;
        pos_next    = pos_adv;
        if (b == 8'h20 || b == 8'h0d || b == 8'h09) begin
          phase_next = sst_pkg::PH_IDLE;
        end else if (b == 8'h0a) begin
          line_next = line_inc;
        end else if (sst_pkg::is_letter(b) || b == 8'h5f) begin
          phase_next  = sst_pkg::PH_IDENT;
          prefix_next = 48'(b);
        end else if (sst_pkg::is_digit(b)) begin
          phase_next = sst_pkg::PH_INT;
        end else if (b == 8'h2f) begin
          phase_next = sst_pkg::PH_SLASH;
        end else if (sst_pkg::is_op(b)) begin
          phase_next   = sst_pkg::PH_OP;
          pending_next = b;
        end else if (b == 8'h22) begin
          phase_next = sst_pkg::PH_STRING;
        end else if (pk[6]) begin
          toks[count] = '{pk[5:0], fit16(EW'(pos)), 16'd1, line16};
          count = count + 2'd1;
        end else begin
          toks[count] = '{sst_pkg::K_ERR_BYTE, fit16(EW'(pos)), 16'd0, line16};
          count = count + 2'd1;
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/script_source_tokenizer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Script source tokenizer
// Streaming lexer: one source byte in, zero to three tokens out.
// ----------------------------------------------------------------------------
// Channel  Handshake              Payload
// src      src_valid/src_ready    source_byte
// tok      tok_valid/tok_ready    token_kind, token_start, token_length,
//                                 token_line, last_of_run
//
// A byte is scanned in the cycle it is accepted and its tokens are held in a
// three-entry result register that drains one token per cycle while
// tok_ready is high. A byte that yields at most one token is taken every
// cycle while tok_ready is high; a byte that yields more holds off the next
// byte until the final token of the previous transaction is being delivered.
// Reset restores the idle scanner state with line one.
// ----------------------------------------------------------------------------
module script_source_tokenizer #(
  parameter int POS_BITS  = sst_pkg::POS_BITS_DEF,
  parameter int LINE_BITS = sst_pkg::LINE_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        src_valid,
  output logic             src_ready,
  input  wire logic [7:0]  source_byte,
  output logic             tok_valid,
  input  wire logic        tok_ready,
  output logic [5:0]       token_kind,
  output logic [15:0]      token_start,
  output logic [15:0]      token_length,
  output logic [15:0]      token_line,
  output logic             last_of_run
);

  sst_pkg::phase_t      phase, phase_next;
  logic [7:0]           pending, pending_next;
  logic [POS_BITS-1:0]  tstart, tstart_next;
  logic [POS_BITS-1:0]  pos, pos_next;
  logic [LINE_BITS-1:0] line, line_next;
  logic [47:0]          prefix, prefix_next;
  sst_pkg::token_t      toks_next [3];
  logic [1:0]           count_next;

  sst_pkg::token_t      slot [3];
  logic [1:0]           left;
  logic [1:0]           head;
  logic                 src_fire;
  logic                 tok_fire;

  sst_scan #(
    .POS_BITS  (POS_BITS),
    .LINE_BITS (LINE_BITS)
  ) u_scan (
    .source_byte  (source_byte),
    .phase        (phase),
    .pending      (pending),
    .tstart       (tstart),
    .pos          (pos),
    .line         (line),
    .prefix       (prefix),
    .phase_next   (phase_next),
    .pending_next (pending_next),
    .tstart_next  (tstart_next),
    .pos_next     (pos_next),
    .line_next    (line_next),
    .prefix_next  (prefix_next),
    .toks         (toks_next),
    .count        (count_next)
  );

  assign tok_valid    = left != 2'd0;
  assign last_of_run  = left == 2'd1;
  assign tok_fire     = tok_valid && tok_ready;
  assign src_ready    = (left == 2'd0) || (left == 2'd1 && tok_ready);
  assign src_fire     = src_valid && src_ready;
  assign token_kind   = slot[head].kind;
  assign token_start  = slot[head].start;
  assign token_length = slot[head].length;
  assign token_line   = slot[head].line;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= sst_pkg::PH_IDLE;
      pending <= '0;
      tstart  <= '0;
      pos     <= '0;
      line    <= LINE_BITS'(1);
      prefix  <= '0;
      left    <= 2'd0;
      head    <= 2'd0;
    end else if (src_fire) begin
      phase   <= phase_next;
      pending <= pending_next;
      tstart  <= tstart_next;
      pos     <= pos_next;
      line    <= line_next;
      prefix  <= prefix_next;
      left    <= count_next;
      head    <= 2'd0;
    end else if (tok_fire) begin
      left <= left - 2'd1;
      head <= head + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (src_fire) begin
      slot <= toks_next;
    end
  end

endmodule
`default_nettype wire

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Script source tokenizer testbench
// Streams source bytes into the tokenizer, predicts every token in step with
// the scanner's own rules, and checks each token that comes out, field by
// field. The stream runs through directed text, keywords and random
// source, stray and high bytes included, under several idle and stall patterns.
// ----------------------------------------------------------------------------
module tb_top;

  typedef struct {
    logic [5:0]  kind;
    logic [15:0] start;
    logic [15:0] length;
    logic [15:0] line;
    logic        last;
  } tok_exp_t;

  localparam int unsigned POS_MAX  = 65535;
  localparam int unsigned LINE_MAX = 65535;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        src_valid = 1'b0;
  logic        src_ready;
  logic [7:0]  source_byte = 8'd0;
  logic        tok_valid;
  logic        tok_ready = 1'b0;
  logic [5:0]  token_kind;
  logic [15:0] token_start;
  logic [15:0] token_length;
  logic [15:0] token_line;
  logic        last_of_run;

  tok_exp_t    tok_q[$];
  tok_exp_t    got_exp;
  int          fail_cnt = 0;
  int          bytes_sent = 0;
  int          toks_seen = 0;
  int          sources_ended = 0;
  int          src_idle_pct = 0;
  int          rdy_stall_pct = 0;

  // Scanner state of the prediction.
  sst_pkg::phase_t ph = sst_pkg::PH_IDLE;
  logic [7:0]  pend = 8'd0;
  int unsigned tstart = 0;
  int unsigned pos = 0;
  int unsigned line_cnt = 1;
  logic [47:0] prefix = 48'd0;
  int          n_out;

  string kw_words [16] = '{"async", "await", "class", "const", "else", "enum", "fn",
    "for", "getlf", "if", "input", "let", "print", "return", "use", "while"};

  script_source_tokenizer dut (
    .clk(clk), .rst(rst),
    .src_valid(src_valid), .src_ready(src_ready), .source_byte(source_byte),
    .tok_valid(tok_valid), .tok_ready(tok_ready),
    .token_kind(token_kind), .token_start(token_start),
    .token_length(token_length), .token_line(token_line),
    .last_of_run(last_of_run)
  );

  always #5 clk = ~clk;

  function automatic bit is_alpha(logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic bit is_num(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic int punct_code(logic [7:0] b);
    case (b)
      "(": return 0;
      ")": return 1;
      "{": return 2;
      "}": return 3;
      "[": return 4;
      "]": return 5;
      ";": return 6;
      ",": return 7;
      ".": return sst_pkg::K_DOT;
      ":": return 9;
      "+": return 10;
      "-": return 11;
      "*": return 12;
      default: return -1;
    endcase
  endfunction

  function automatic logic [5:0] cmp_code(logic [7:0] b);
    case (b)
      "!": return sst_pkg::K_BANG;
      "=": return sst_pkg::K_ASSIGN;
      "<": return sst_pkg::K_LESS;
      default: return sst_pkg::K_GREATER;
    endcase
  endfunction

  function automatic logic [5:0] word_code(int unsigned len);
    bit same;
    for (int i = 0; i < 16; i++) begin
      same = (len == kw_words[i].len());
      for (int j = 0; same && j < kw_words[i].len(); j++)
        if (prefix[8*j +: 8] != kw_words[i][j]) same = 0;
      if (same) return 6'(25 + i);
    end
    return sst_pkg::K_IDENT;
  endfunction

  function automatic int unsigned span();
    return pos > tstart ? pos - tstart : 0;
  endfunction

  function automatic void bump();
    if (pos < POS_MAX) pos++;
  endfunction

  function automatic void put_tok(logic [5:0] kind, int unsigned st, int unsigned ln);
    tok_exp_t t;
    if (n_out >= 3) return;
    t.kind = kind;
    t.start = st[15:0];
    t.length = ln[15:0];
    t.line = line_cnt[15:0];
    t.last = 1'b0;
    tok_q.push_back(t);
    n_out++;
  endfunction

  function automatic void scan_fresh(logic [7:0] b);
    int pk;
    if (b == 8'd0) begin
      put_tok(sst_pkg::K_EOF, pos, 0);
      pos = 0;
      line_cnt = 1;
      ph = sst_pkg::PH_IDLE;
      sources_ended++;
      return;
    end
    ph = sst_pkg::PH_IDLE;
    tstart = pos;
    if (b == " " || b == 8'h0d || b == 8'h09) begin
      bump();
      return;
    end
    if (b == 8'h0a) begin
      if (line_cnt < LINE_MAX) line_cnt++;
      bump();
      return;
    end
    if (is_alpha(b) || b == "_") begin
      ph = sst_pkg::PH_IDENT;
      prefix = 48'(b);
    end else if (is_num(b)) begin
      ph = sst_pkg::PH_INT;
    end else if (b == "/") begin
      ph = sst_pkg::PH_SLASH;
    end else if (b == "!" || b == "=" || b == "<" || b == ">") begin
      ph = sst_pkg::PH_OP;
      pend = b;
    end else if (b == 8'h22) begin
      ph = sst_pkg::PH_STRING;
    end else begin
      pk = punct_code(b);
      if (pk >= 0) put_tok(6'(pk), pos, 1);
      else put_tok(sst_pkg::K_ERR_BYTE, pos, 0);
    end
    bump();
  endfunction

  function automatic void predict_byte(logic [7:0] b);
    int unsigned n;
    n_out = 0;
    case (ph)
      sst_pkg::PH_IDENT: begin
        if (is_alpha(b) || is_num(b) || b == "_") begin
          n = span();
          if (n < 6) prefix |= 48'(b) << (8 * n);
          bump();
        end else begin
          put_tok(word_code(span()), tstart, span());
          scan_fresh(b);
        end
      end
      sst_pkg::PH_INT, sst_pkg::PH_FRAC: begin
        if (is_num(b)) begin
          bump();
        end else if (b == "." && ph == sst_pkg::PH_INT) begin
          ph = sst_pkg::PH_DOT;
          pend = b;
          bump();
        end else begin
          put_tok(sst_pkg::K_NUMBER, tstart, span());
          scan_fresh(b);
        end
      end
      sst_pkg::PH_DOT: begin
        if (is_num(b)) begin
          ph = sst_pkg::PH_FRAC;
          bump();
        end else begin
          n = span();
          n = n > 0 ? n - 1 : 0;
          put_tok(sst_pkg::K_NUMBER, tstart, n);
          put_tok(sst_pkg::K_DOT, tstart + n, 1);
          scan_fresh(b);
        end
      end
      sst_pkg::PH_OP: begin
        if (b == "=") begin
          put_tok(cmp_code(pend) + 6'd1, tstart, 2);
          ph = sst_pkg::PH_IDLE;
          bump();
        end else begin
          put_tok(cmp_code(pend), tstart, 1);
          scan_fresh(b);
        end
      end
      sst_pkg::PH_SLASH: begin
        if (b == "/") begin
          ph = sst_pkg::PH_COMMENT;
          bump();
        end else begin
          put_tok(sst_pkg::K_SLASH, tstart, 1);
          scan_fresh(b);
        end
      end
      sst_pkg::PH_COMMENT: begin
        if (b == 8'd0 || b == 8'h0a) scan_fresh(b);
        else bump();
      end
      sst_pkg::PH_STRING: begin
        if (b == 8'd0) begin
          put_tok(sst_pkg::K_ERR_STR, tstart, 0);
          scan_fresh(b);
        end else if (b == 8'h22) begin
          n = span();
          n = n > 0 ? n - 1 : 0;
          put_tok(sst_pkg::K_STRING, tstart + 1, n);
          ph = sst_pkg::PH_IDLE;
          bump();
        end else begin
          if (b == 8'h0a && line_cnt < LINE_MAX) line_cnt++;
          bump();
        end
      end
      default: scan_fresh(b);
    endcase
    if (n_out > 0) tok_q[tok_q.size() - 1].last = 1'b1;
  endfunction

  task automatic send_byte(logic [7:0] b);
    if (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
      src_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < src_idle_pct) @(posedge clk);
    end
    src_valid <= 1'b1;
    source_byte <= b;
    do @(posedge clk); while (!src_ready);
    predict_byte(b);
    bytes_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic wait_drained();
    src_valid <= 1'b0;
    while (tok_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [7:0] pick(string set);
    return set[$urandom_range(set.len() - 1)];
  endfunction

  task automatic test_directed();
    send_text("(){}[];,.:+-*!=!x==a=<=<b>=>c/ 1.5 7.a 12.");
    send_text({"\"s\"", 8'h0a, "\"\"\"ab", 8'h0a, "c\"@#"});
    send_byte(8'hff);
    send_byte(8'h80);
    send_text({"x//note", 8'h0a, 8'h09, 8'h0d, "q"});
    send_byte(8'd0);
    send_text("\"open");
    send_byte(8'd0);
    send_text("x/");
    send_byte(8'd0);
    wait_drained();
  endtask

  task automatic test_keywords();
    for (int i = 0; i < 16; i++) send_text({kw_words[i], " ", kw_words[i], "s "});
    send_text("_Abc_Z9long_name retur");
    send_byte(8'd0);
    wait_drained();
  endtask

  task automatic test_random(int count);
    int goal;
    int len;
    goal = bytes_sent + count;
    while (bytes_sent < goal) begin
      case ($urandom_range(12))
        0: send_text(kw_words[$urandom_range(15)]);
        1: send_text({kw_words[$urandom_range(15)], pick("a_9Z")});
        2: begin
          send_byte(pick("abcxyzAQZ_"));
          len = $urandom_range(8);
          repeat (len) send_byte(pick("aeiorstwxzAZ_09"));
        end
        3: repeat ($urandom_range(1, 4)) send_byte(pick("0123456789"));
        4: begin
          send_byte(pick("0123456789"));
          send_byte(".");
          repeat ($urandom_range(3)) send_byte(pick("0189"));
        end
        5: begin
          send_byte("\"");
          repeat ($urandom_range(5)) send_byte(pick({"ab ./=!1", 8'h0a}));
          if ($urandom_range(5) != 0) send_byte("\"");
        end
        6: begin
          send_byte(pick("!=<>"));
          if ($urandom_range(1)) send_byte("=");
        end
        7: send_byte(pick("(){}[];,.:+-*/"));
        8: begin
          send_text("//");
          repeat ($urandom_range(4)) send_byte(pick("ab \"/*"));
          send_byte(8'h0a);
        end
        9: send_byte(pick({" ", 8'h09, 8'h0d, 8'h0a}));
        10: send_byte(8'($urandom_range(1, 255)));
        11: send_byte(8'($urandom_range(128, 255)));
        default: if ($urandom_range(2) == 0) send_byte(8'd0);
      endcase
      if ($urandom_range(1)) send_byte(pick({" ", 8'h0a}));
    end
    send_byte(8'd0);
  endtask

  always @(posedge clk) begin
    if (!rst && tok_valid && tok_ready) begin
      toks_seen++;
      if (tok_q.size() == 0) begin
        fail_cnt++;
        $display("%0t: token with nothing expected: kind %0d start %0d len %0d line %0d",
                 $time, token_kind, token_start, token_length, token_line);
      end else begin
        got_exp = tok_q.pop_front();
        if (token_kind !== got_exp.kind || token_start !== got_exp.start ||
            token_length !== got_exp.length || token_line !== got_exp.line ||
            last_of_run !== got_exp.last) begin
          fail_cnt++;
          $display("%0t: expected kind %0d start %0d len %0d line %0d last %0b",
                   $time, got_exp.kind, got_exp.start, got_exp.length, got_exp.line,
                   got_exp.last);
          $display("%0t:   actual kind %0d start %0d len %0d line %0d last %0b",
                   $time, token_kind, token_start, token_length, token_line, last_of_run);
        end
      end
    end
    tok_ready <= ($urandom_range(99) >= rdy_stall_pct);
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);
    test_directed();
    test_keywords();
    test_random(32);
    wait_drained();
    src_idle_pct = 52;
    test_random(32);
    wait_drained();
    src_idle_pct = 0;
    rdy_stall_pct = 52;
    test_random(32);
    wait_drained();
    src_idle_pct = 8;
    rdy_stall_pct = 8;
    test_random(32);
    wait_drained();
    repeat (20) @(posedge clk);
    $display("Streamed %0d source bytes over %0d sources; %0d tokens checked.",
             bytes_sent, sources_ended, toks_seen);
    $display("Covered all kinds, lookahead splits, keywords and four handshake patterns.");
    if (fail_cnt == 0 && tok_q.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("Timed out with %0d tokens still expected.", tok_q.size());
    $display("tb_top NOT OK");
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/sst_pkg.sv
hw/rtl/sst_scan.sv
hw/rtl/script_source_tokenizer.sv
verif/tb_top.sv
